### src/rsas_pkg.sv
// Shared field widths, operation codes and types for the rotated array search unit.
package rsas_pkg;

    localparam int FUNC_W = 1;
    localparam int IDX_W  = 10;
    localparam int VAL_W  = 32;
    localparam int CNT_W  = 11;

    localparam logic [FUNC_W-1:0] FUNC_WRITE  = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 1'b1;

    typedef logic [FUNC_W-1:0]       t_func;
    typedef logic [IDX_W-1:0]        t_index;
    typedef logic signed [VAL_W-1:0] t_value;
    typedef logic [CNT_W-1:0]        t_count;

endpackage

### src/rsas_in_if.sv
// Input channel: valid/ready handshake carrying one operation word.
interface rsas_in_if;
    import rsas_pkg::*;

    logic   valid;
    logic   ready;
    t_func  func;
    t_index index;
    t_value value;

    modport source (output valid, output func, output index, output value, input ready);
    modport sink   (input valid, input func, input index, input value, output ready);
endinterface

### src/rsas_out_if.sv
// Output channel: valid/ready handshake carrying one result word.
interface rsas_out_if;
    import rsas_pkg::*;

    logic   valid;
    logic   ready;
    logic   found;
    t_index position;

    modport source (output valid, output found, output position, input ready);
    modport sink   (input valid, input found, input position, output ready);
endinterface

### src/rsas_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rsas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### src/rotated_sorted_array_search_unit.sv
// Rotated sorted array search unit: element store, pivot search and binary search.
// A write is answered in the cycle after acceptance; writes can follow every cycle unless stalled.
// A search runs a setup read of entry 0, a pivot search and a binary search (n = element count),
// step by step, as set by the single RAM read port and the one shared comparator; the next word
// is taken only after the search has finished and the sequencer is back in idle.
// Reset (synchronous, active low) idles the sequencer, empties the output and sets the count to 1.
module rotated_sorted_array_search_unit #(
    parameter int DEPTH = 1024
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  rsas_pkg::t_count       i_cfg_wdata,
    rsas_in_if.sink                i_in,
    rsas_out_if.source             o_out
);
    import rsas_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int SW = AW + 2;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_E0    = 3'd1;
    localparam logic [2:0] S_PSTEP = 3'd2;
    localparam logic [2:0] S_PCMP  = 3'd3;
    localparam logic [2:0] S_GPIV  = 3'd4;
    localparam logic [2:0] S_GLAST = 3'd5;
    localparam logic [2:0] S_BSTEP = 3'd6;
    localparam logic [2:0] S_BCMP  = 3'd7;

    logic [2:0]           r_state, n_state;
    t_count               r_element_count;
    logic signed [SW-1:0] r_lo, n_lo;
    logic signed [SW-1:0] r_hi, n_hi;
    logic signed [SW-1:0] r_mid, n_mid;
    logic signed [SW-1:0] r_piv, n_piv;
    logic signed [SW-1:0] r_nm1, n_nm1;
    t_value               r_key, n_key;
    t_value               r_e0, n_e0;
    logic                 r_ge, n_ge;
    logic                 r_ovalid, n_ovalid;
    logic                 r_found, n_found;
    t_index               r_pos, n_pos;

    logic                 w_accept;
    logic                 w_we;
    logic [AW-1:0]        w_raddr;
    t_value               w_rdata;
    logic signed [SW-1:0] w_mid;
    logic [31:0]          w_n;
    t_value               w_cmp_a, w_cmp_b;
    logic                 w_eq, w_gt, w_lt;

    rsas_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(i_in.index)),
        .i_wdata (i_in.value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign i_in.ready = (r_state == S_IDLE) && (!r_ovalid || o_out.ready);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_we       = w_accept && (i_in.func == FUNC_WRITE) &&
                        (32'(i_in.index) < 32'(DEPTH));

    assign o_out.valid    = r_ovalid;
    assign o_out.found    = r_found;
    assign o_out.position = r_pos;

    // Effective count, clamped into 1..DEPTH.
    always_comb begin
        if (r_element_count == '0) begin
            w_n = 32'd1;
        end else if (32'(r_element_count) > 32'(DEPTH)) begin
            w_n = 32'(DEPTH);
        end else begin
            w_n = 32'(r_element_count);
        end
    end

    assign w_mid = r_lo + ((r_hi - r_lo) >>> 1);

    // The one comparator; only the pivot step compares a stored word against entry 0.
    assign w_cmp_a = (r_state == S_PCMP) ? w_rdata : r_key;
    assign w_cmp_b = (r_state == S_PCMP) ? r_e0 : w_rdata;
    assign w_eq    = (w_cmp_a == w_cmp_b);
    assign w_gt    = (w_cmp_a > w_cmp_b);
    assign w_lt    = (w_cmp_a < w_cmp_b);

    always_comb begin
        n_state  = r_state;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_piv    = r_piv;
        n_nm1    = r_nm1;
        n_key    = r_key;
        n_e0     = r_e0;
        n_ge     = r_ge;
        n_found  = r_found;
        n_pos    = r_pos;
        n_ovalid = r_ovalid && !o_out.ready;
        w_raddr  = '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in.func == FUNC_WRITE) begin
                        n_ovalid = 1'b1;
                        n_found  = 1'b0;
                        n_pos    = i_in.index;
                    end else begin
                        n_key   = i_in.value;
                        n_nm1   = SW'(w_n - 32'd1);
                        n_lo    = '0;
                        n_hi    = SW'(w_n - 32'd1);
                        n_state = S_E0;
                    end
                end
            end
            S_E0: begin
                n_e0    = w_rdata;
                n_state = S_PSTEP;
            end
            S_PSTEP: begin
                if (r_lo < r_hi) begin
                    w_raddr = AW'(w_mid);
                    n_mid   = w_mid;
                    n_state = S_PCMP;
                end else begin
                    w_raddr = AW'(r_lo);
                    n_piv   = r_lo;
                    n_state = S_GPIV;
                end
            end
            S_PCMP: begin
                if (!w_lt) begin
                    n_lo = r_mid + SW'(1);
                end else begin
                    n_hi = r_mid;
                end
                n_state = S_PSTEP;
            end
            S_GPIV: begin
                n_ge    = !w_lt;
                w_raddr = AW'(r_nm1);
                n_state = S_GLAST;
            end
            S_GLAST: begin
                if (r_ge && !w_gt) begin
                    n_lo = r_piv;
                    n_hi = r_nm1;
                end else begin
                    n_lo = '0;
                    n_hi = r_piv - SW'(1);
                end
                n_state = S_BSTEP;
            end
            S_BSTEP: begin
                if (r_lo <= r_hi) begin
                    w_raddr = AW'(w_mid);
                    n_mid   = w_mid;
                    n_state = S_BCMP;
                end else begin
                    n_ovalid = 1'b1;
                    n_found  = 1'b0;
                    n_pos    = '0;
                    n_state  = S_IDLE;
                end
            end
            S_BCMP: begin
                if (w_eq) begin
                    n_ovalid = 1'b1;
                    n_found  = 1'b1;
                    n_pos    = IDX_W'($unsigned(r_mid));
                    n_state  = S_IDLE;
                end else if (w_gt) begin
                    n_lo    = r_mid + SW'(1);
                    n_state = S_BSTEP;
                end else begin
                    n_hi    = r_mid - SW'(1);
                    n_state = S_BSTEP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_ovalid        <= 1'b0;
            r_element_count <= CNT_W'(1);
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_element_count <= i_cfg_wdata;
            end
        end
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_piv   <= n_piv;
        r_nm1   <= n_nm1;
        r_key   <= n_key;
        r_e0    <= n_e0;
        r_ge    <= n_ge;
        r_found <= n_found;
        r_pos   <= n_pos;
    end

`ifndef ASSERT_OFF
    // An accepted search always starts by waiting for entry 0.
    a_search_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in.func == FUNC_SEARCH)) |=> (r_state == S_E0))
        else $error("search did not start with the entry 0 read");

    // An accepted write is answered in the next cycle with found low.
    a_write_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in.func == FUNC_WRITE)) |=> (r_ovalid && !r_found))
        else $error("write word not echoed");

    // The pivot search window stays inside the covered entries.
    a_pivot_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PSTEP) |-> ((r_lo >= 0) && (r_hi <= r_nm1) && (r_lo <= r_hi)))
        else $error("pivot window out of range");

    // Every probe of the binary search reads a covered entry.
    a_probe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BCMP) |-> ((r_mid >= 0) && (r_mid <= r_nm1)))
        else $error("binary search probe out of range");

    // A finished search never overwrites a result still waiting at the output.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !o_out.ready) |=> r_ovalid && $stable(r_pos) && $stable(r_found))
        else $error("pending result lost");
`endif
endmodule
